// ===== src/adcq_pkg.sv =====
`timescale 1ns / 1ps

package adcq_pkg;

    // signed millivolt fields
    localparam int V_W = 18;
    // resolution register and its write data
    localparam int RES_W = 4;
    localparam logic [RES_W-1:0] RES_RESET = 4'd8;
    localparam logic [RES_W-1:0] RES_MIN = 4'd2;
    // conversion delay register
    localparam int DELAY_W = 20;
    localparam logic [DELAY_W-1:0] DELAY_MAX = 20'd1000000;
    // fraction of the difference handed to the divider sits above this many bits
    localparam int REM_W = V_W + 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_UPD  = 5'b10000
    } t_state;

endpackage

// ===== src/adc_quantizer_with_latency.sv =====
`timescale 1ns / 1ps

// A request accepted in S_IDLE passes S_PREP, S_MUL, S_DIV (one restoring-divider step
//   per quotient bit) and S_UPD when a code is worked out, or goes from S_PREP straight
//   to S_UPD when a pin is open or the references are out of order. A finished result
//   waits in S_UPD until the output register is free; only then is a new request taken.
// The input side stalls while a request is in flight; a finished result waits in the
//   output register. Reset (synchronous, active low) sets 8 bits, zero delay, no output.
module adc_quantizer_with_latency
    import adcq_pkg::*;
#(
    parameter int MAX_BITS   = 12,
    parameter int TIME_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [V_W-1:0] i_vin_mv,
    input  logic                  i_vin_connected,
    input  logic signed [V_W-1:0] i_vref_low_mv,
    input  logic                  i_vref_low_connected,
    input  logic signed [V_W-1:0] i_vref_high_mv,
    input  logic                  i_vref_high_connected,
    input  logic [TIME_WIDTH-1:0] i_now_us,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [MAX_BITS-1:0]   o_out_code,
    output logic                  o_out_valid,
    output logic                  o_busy_res,
    output logic                  o_warn_input_floating,
    output logic                  o_warn_ref_open,
    output logic                  o_warn_ref_order,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DELAY_W-1:0]    i_cfg_data
);

    localparam int NUM_W = MAX_BITS + REM_W + 1;

    t_state r_state, n_state;

    // configuration
    logic [RES_W-1:0]   r_res;
    logic [DELAY_W-1:0] r_delay;

    // converter state
    logic [MAX_BITS-1:0]   r_cur, n_cur;
    logic [MAX_BITS-1:0]   r_sched, n_sched;
    logic [TIME_WIDTH-1:0] r_apply, n_apply;
    logic                  r_have, n_have;
    logic                  r_wait, n_wait;

    // request being worked on
    logic signed [V_W-1:0] r_vin, r_vlo, r_vhi;
    logic                  r_vin_ok, r_vlo_ok, r_vhi_ok;
    logic [TIME_WIDTH-1:0] r_now;
    logic [V_W-1:0]        r_n, r_d;
    logic                  r_ok;
    logic                  r_warn_order;
    logic [TIME_WIDTH-1:0] r_tnew;
    logic [MAX_BITS-1:0]   r_target;

    logic r_out_valid;

    // datapath
    logic signed [V_W:0]   w_diff;
    logic signed [V_W:0]   w_nraw;
    logic                  w_all_conn;
    logic                  w_ok;
    logic [V_W-1:0]        w_n;
    logic [NUM_W-1:0]      w_num;
    logic [TIME_WIDTH:0]   w_tsum;
    logic [TIME_WIDTH-1:0] w_tsat;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [MAX_BITS-1:0]   w_div_quo;
    logic                  w_commit;
    logic                  w_resched;

    // configuration
    logic                  w_cfg_we;
    logic [RES_W-1:0]      w_bits;
    logic [MAX_BITS-1:0]   w_mcode;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_commit    = (r_state == S_UPD) && (!r_out_valid || !i_stall);
    assign w_div_start = (r_state == S_MUL);

    always_comb begin
        w_diff     = $signed({r_vhi[V_W-1], r_vhi}) - $signed({r_vlo[V_W-1], r_vlo});
        w_nraw     = $signed({r_vin[V_W-1], r_vin}) - $signed({r_vlo[V_W-1], r_vlo});
        w_all_conn = r_vin_ok && r_vlo_ok && r_vhi_ok;
        w_ok       = w_all_conn && (w_diff > 0);
        priority if (w_nraw < 0) begin
            w_n = '0;
        end else if (w_nraw > w_diff) begin
            w_n = w_diff[V_W-1:0];
        end else begin
            w_n = w_nraw[V_W-1:0];
        end
    end

    // 2*n*(2^bits - 1) + d as shift and subtract
    always_comb begin
        w_num  = (((NUM_W'(r_n) << r_res) - NUM_W'(r_n)) << 1) + NUM_W'(r_d);
        w_tsum = {1'b0, r_now} + (TIME_WIDTH + 1)'(r_delay);
        w_tsat = w_tsum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : w_tsum[TIME_WIDTH-1:0];
    end

    adcq_div #(
        .MAX_BITS (MAX_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   ({r_d, 1'b0}),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_PREP;
            S_PREP: n_state = w_ok ? S_MUL : S_UPD;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (w_div_done) n_state = S_UPD;
            S_UPD:  if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // resolution write: clamp to 2..MAX_BITS, then clamp the stored codes
    always_comb begin
        priority if (i_cfg_data[RES_W-1:0] < RES_MIN) begin
            w_bits = RES_MIN;
        end else if (i_cfg_data[RES_W-1:0] > MAX_BITS) begin
            w_bits = RES_W'(MAX_BITS);
        end else begin
            w_bits = i_cfg_data[RES_W-1:0];
        end
        w_mcode = ~({MAX_BITS{1'b1}} << w_bits);
    end

    always_comb begin
        n_cur   = r_cur;
        n_sched = r_sched;
        n_apply = r_apply;
        n_have  = r_have;
        n_wait  = r_wait;
        w_resched = r_wait ? (r_target != r_sched) : (!r_have || (r_target != r_cur));
        if (w_cfg_we && (i_cfg_index == CFG_RES)) begin
            if (r_cur > w_mcode) n_cur = w_mcode;
            if (r_sched > w_mcode) n_sched = w_mcode;
        end else if (w_commit) begin
            if (r_ok && w_resched) begin
                n_sched = r_target;
                n_apply = r_tnew;
                n_wait  = 1'b1;
            end
            // a pending code completes once its time is reached
            if (n_wait && (r_now >= n_apply)) begin
                n_cur  = n_sched;
                n_have = 1'b1;
                n_wait = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res       <= RES_RESET;
            r_delay     <= '0;
            r_cur       <= '0;
            r_sched     <= '0;
            r_apply     <= '0;
            r_have      <= 1'b0;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_sched <= n_sched;
            r_apply <= n_apply;
            r_have  <= n_have;
            r_wait  <= n_wait;
            if (w_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RES:   r_res <= w_bits;
                    CFG_DELAY: r_delay <= (i_cfg_data > DELAY_MAX) ? DELAY_MAX : i_cfg_data;
                    default: ;
                endcase
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_vin    <= i_vin_mv;
            r_vlo    <= i_vref_low_mv;
            r_vhi    <= i_vref_high_mv;
            r_vin_ok <= i_vin_connected;
            r_vlo_ok <= i_vref_low_connected;
            r_vhi_ok <= i_vref_high_connected;
            r_now    <= i_now_us;
        end
        if (r_state == S_PREP) begin
            r_n          <= w_n;
            r_d          <= w_diff[V_W-1:0];
            r_ok         <= w_ok;
            r_warn_order <= w_all_conn && !(w_diff > 0);
        end
        if (r_state == S_MUL) begin
            r_tnew <= w_tsat;
        end
        if (r_state == S_DIV && w_div_done) begin
            r_target <= w_div_quo;
        end
        if (w_commit) begin
            o_out_code            <= n_have ? n_cur : '0;
            o_out_valid           <= n_have;
            o_busy_res            <= n_wait;
            o_warn_input_floating <= !r_vin_ok;
            o_warn_ref_open       <= !(r_vlo_ok && r_vhi_ok);
            o_warn_ref_order      <= r_warn_order;
        end
    end

`ifndef ASSERT_OFF
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res >= RES_MIN) && (r_res <= MAX_BITS))
        else $error("resolution register out of range");

    a_code_zero_without_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_valid) |-> (o_out_code == '0))
        else $error("nonzero code reported before any conversion completed");

    a_commit_only_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> ($past(r_state) == S_PREP || $past(r_state) == S_DIV
                      || $past(r_state) == S_UPD))
        else $error("result committed without a finished request");
`endif

endmodule

// ===== src/adcq_div.sv =====
`timescale 1ns / 1ps

module adcq_div
    import adcq_pkg::*;
#(
    parameter int MAX_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [MAX_BITS+REM_W:0] i_num,
    input  logic [REM_W-1:0]        i_den,
    output logic                    o_done,
    output logic [MAX_BITS-1:0]     o_quo
);

    localparam int NUM_W = MAX_BITS + REM_W + 1;
    localparam int CNT_W = $clog2(MAX_BITS + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_BITS - 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [REM_W-1:0]    r_rem;
    logic [REM_W-1:0]    r_den;
    logic [MAX_BITS-1:0] r_low;

    logic [REM_W:0] w_trial;
    logic           w_fit;
    logic [REM_W:0] w_diff;

    // quotient fits MAX_BITS bits, so the upper part of the numerator is below den
    always_comb begin
        w_trial = {r_rem, r_low[MAX_BITS-1]};
        w_fit   = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_W-2 -: REM_W];
            r_low <= i_num[MAX_BITS-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            // one restoring step: shift in the next numerator bit, keep the quotient bit
            r_rem <= w_fit ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
            r_low <= {r_low[MAX_BITS-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_low;

endmodule

// ===== sim/tb_adc_quantizer_with_latency.sv =====
`timescale 1ns / 1ps

module tb_adc_quantizer_with_latency;
    import adcq_pkg::*;

    localparam int MAXB = 12;
    localparam int TW = 48;
    localparam logic [TW-1:0] TIME_MAX = '1;
    localparam int V_LIM = 100000;
    localparam int SETTLE_CYCLES = 2 * (MAXB + 5);
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int N_PHASES = 10;
    localparam int PHASE_ITEMS = 155;
    localparam int NDIR = 29;
    localparam bit ROW_STEP = 1'b0;
    localparam bit ROW_CFG = 1'b1;

    typedef struct {
        logic signed [V_W-1:0] vin;
        logic                  vin_on;
        logic signed [V_W-1:0] lo;
        logic                  lo_on;
        logic signed [V_W-1:0] hi;
        logic                  hi_on;
        logic [TW-1:0]         now;
    } t_sample;

    typedef struct {
        logic [MAXB-1:0] code;
        logic            valid;
        logic            busy;
        logic            floating;
        logic            ref_open;
        logic            ref_order;
    } t_reading;

    typedef struct {
        bit                   kind;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [DELAY_W-1:0]   cfg_data;
        t_sample              s;
        bit                   pin;
        t_reading             r;
    } t_row;

    localparam t_sample NO_SAMPLE = '{default: '0};
    localparam t_reading NO_READ = '{default: '0};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic signed [V_W-1:0] i_vin_mv;
    logic                  i_vin_connected;
    logic signed [V_W-1:0] i_vref_low_mv;
    logic                  i_vref_low_connected;
    logic signed [V_W-1:0] i_vref_high_mv;
    logic                  i_vref_high_connected;
    logic [TW-1:0]         i_now_us;
    logic                  o_valid;
    logic                  i_stall;
    logic [MAXB-1:0]       o_out_code;
    logic                  o_out_valid;
    logic                  o_busy_res;
    logic                  o_warn_input_floating;
    logic                  o_warn_ref_open;
    logic                  o_warn_ref_order;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [DELAY_W-1:0]    i_cfg_data;

    // predictor copy of the converter
    logic [RES_W-1:0]   cfg_bits;
    logic [DELAY_W-1:0] cfg_delay;
    logic [MAXB-1:0]    pred_code;
    logic [MAXB-1:0]    pred_sched;
    logic [TW-1:0]      pred_apply;
    bit                 pred_have;
    bit                 pred_pending;

    t_reading readings_due[$];
    int       mismatches;
    int       n_results;
    int       quiet_cycles;

    bit       pin_on;
    t_reading pin_reading;
    bit       tx_quiet;
    bit       rx_quiet;
    bit       hold_off_req;

    logic [TW-1:0] now_t;
    int            last_lo;
    int            last_hi;
    int            last_vin;

    t_row dir_tab [NDIR];

    adc_quantizer_with_latency #(
        .MAX_BITS  (MAXB),
        .TIME_WIDTH(TW)
    ) u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_vin_mv             (i_vin_mv),
        .i_vin_connected      (i_vin_connected),
        .i_vref_low_mv        (i_vref_low_mv),
        .i_vref_low_connected (i_vref_low_connected),
        .i_vref_high_mv       (i_vref_high_mv),
        .i_vref_high_connected(i_vref_high_connected),
        .i_now_us             (i_now_us),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_out_code           (o_out_code),
        .o_out_valid          (o_out_valid),
        .o_busy_res           (o_busy_res),
        .o_warn_input_floating(o_warn_input_floating),
        .o_warn_ref_open      (o_warn_ref_open),
        .o_warn_ref_order     (o_warn_ref_order),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report(string msg);
        $display("mismatch at result %0d: %s", n_results, msg);
        mismatches++;
    endtask

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic int rand_mv();
        return int'($urandom_range(0, 2 * V_LIM)) - V_LIM;
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [DELAY_W-1:0] data);
        logic [RES_W-1:0] b;
        logic [MAXB-1:0]  top;
        if (idx == CFG_RES) begin
            b = data[RES_W-1:0];
            if (b < RES_MIN) b = RES_MIN;
            if (b > MAXB) b = RES_W'(MAXB);
            cfg_bits = b;
            top = MAXB'((1 << cfg_bits) - 1);
            // shrinking the resolution clamps both stored codes
            if (pred_code > top) pred_code = top;
            if (pred_sched > top) pred_sched = top;
        end else if (idx == CFG_DELAY) begin
            cfg_delay = (data > DELAY_MAX) ? DELAY_MAX : data;
        end
    endfunction

    function automatic t_reading quantize_step(t_sample s);
        t_reading        r;
        logic [MAXB-1:0] top;
        logic [MAXB-1:0] tgt;
        logic [TW:0]     due;
        longint          d;
        longint          n;
        bit              all_on;
        bit              order_bad;
        bit              need;
        top = MAXB'((1 << cfg_bits) - 1);
        all_on = s.vin_on && s.lo_on && s.hi_on;
        order_bad = all_on && (s.hi <= s.lo);
        if (all_on && !order_bad) begin
            d = longint'(s.hi) - longint'(s.lo);
            n = longint'(s.vin) - longint'(s.lo);
            if (n < 0) n = 0;
            if (n > d) n = d;
            // round half up in integers
            tgt = MAXB'((2 * n * longint'(top) + d) / (2 * d));
            need = pred_pending ? (tgt != pred_sched) : (!pred_have || tgt != pred_code);
            if (need) begin
                due = {1'b0, s.now} + cfg_delay;
                pred_sched = tgt;
                pred_apply = due[TW] ? TIME_MAX : due[TW-1:0];
                pred_pending = 1'b1;
            end
        end
        if (pred_pending && s.now >= pred_apply) begin
            pred_code = pred_sched;
            pred_have = 1'b1;
            pred_pending = 1'b0;
        end
        r.code = pred_have ? pred_code : '0;
        r.valid = pred_have;
        r.busy = pred_pending;
        r.floating = !s.vin_on;
        r.ref_open = !(s.lo_on && s.hi_on);
        r.ref_order = order_bad;
        return r;
    endfunction

    // scoreboard: results first, then config writes, then new requests
    always @(posedge i_clk) begin : monitor
        t_reading want;
        t_sample  s;
        if (!i_rst_n) begin
            cfg_bits = RES_RESET;
            cfg_delay = '0;
            pred_code = '0;
            pred_sched = '0;
            pred_apply = '0;
            pred_have = 1'b0;
            pred_pending = 1'b0;
            readings_due.delete();
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (readings_due.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    want = readings_due.pop_front();
                    if (o_out_code !== want.code)
                        report($sformatf("code %0d, want %0d", o_out_code, want.code));
                    if (o_out_valid !== want.valid)
                        report($sformatf("out_valid %b, want %b", o_out_valid, want.valid));
                    if (o_busy_res !== want.busy)
                        report($sformatf("busy %b, want %b", o_busy_res, want.busy));
                    if (o_warn_input_floating !== want.floating)
                        report($sformatf("floating %b, want %b", o_warn_input_floating,
                            want.floating));
                    if (o_warn_ref_open !== want.ref_open)
                        report($sformatf("ref_open %b, want %b", o_warn_ref_open,
                            want.ref_open));
                    if (o_warn_ref_order !== want.ref_order)
                        report($sformatf("ref_order %b, want %b", o_warn_ref_order,
                            want.ref_order));
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                apply_write(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall) begin
                s.vin = i_vin_mv;
                s.vin_on = i_vin_connected;
                s.lo = i_vref_low_mv;
                s.lo_on = i_vref_low_connected;
                s.hi = i_vref_high_mv;
                s.hi_on = i_vref_high_connected;
                s.now = i_now_us;
                want = quantize_step(s);
                if (pin_on) want = pin_reading;
                readings_due.push_back(want);
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int hold;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold = HOLD_OFF_CYCLES;
            end else begin
                hold = pick_gap(rx_quiet);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send(t_sample s);
        int gap;
        i_vin_mv <= s.vin;
        i_vin_connected <= s.vin_on;
        i_vref_low_mv <= s.lo;
        i_vref_low_connected <= s.lo_on;
        i_vref_high_mv <= s.hi;
        i_vref_high_connected <= s.hi_on;
        i_now_us <= s.now;
        i_valid <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        @(negedge i_clk);
        gap = pick_gap(tx_quiet);
        // hold valid high when the next request follows at once
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DELAY_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (readings_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic make_sample(output t_sample s);
        int r;
        int lo;
        int hi;
        int span;
        int vin;
        r = $urandom_range(0, 99);
        if (r < 5)
            now_t = now_t - $urandom_range(0, cfg_delay + 100);
        else if (r < 7)
            now_t = TIME_MAX - $urandom_range(0, cfg_delay + 20);
        else if (r < 11)
            now_t = TW'({$urandom(), $urandom()});
        else
            now_t = now_t + $urandom_range(0, cfg_delay / 3 + 3);

        lo = last_lo;
        hi = last_hi;
        if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                // narrow window to exercise rounding
                span = $urandom_range(1, 600);
                lo = int'($urandom_range(0, 2 * V_LIM - span)) - V_LIM;
                hi = lo + span;
            end else begin
                lo = rand_mv();
                hi = rand_mv();
                if (lo > hi) begin
                    span = lo;
                    lo = hi;
                    hi = span;
                end
                if (lo == hi) begin
                    if (hi < V_LIM) hi++;
                    else lo--;
                end
            end
        end

        r = $urandom_range(0, 99);
        if (r < 20)
            vin = last_vin;
        else if (r < 30)
            vin = lo - int'($urandom_range(0, lo + V_LIM));
        else if (r < 40)
            vin = hi + int'($urandom_range(0, V_LIM - hi));
        else
            vin = lo + int'($urandom_range(0, hi - lo));
        last_lo = lo;
        last_hi = hi;
        last_vin = vin;

        s.vin = vin;
        s.vin_on = 1'b1;
        s.lo = lo;
        s.lo_on = 1'b1;
        s.hi = hi;
        s.hi_on = 1'b1;
        s.now = now_t;

        r = $urandom_range(0, 99);
        if (r < 8) begin
            s.vin = rand_mv();
            s.lo = rand_mv();
            s.hi = rand_mv();
            s.vin_on = $urandom_range(0, 1);
            s.lo_on = $urandom_range(0, 1);
            s.hi_on = $urandom_range(0, 1);
        end else if (r < 14) begin
            // references crossed or equal
            s.lo = hi;
            s.hi = ($urandom_range(0, 1) == 0) ? lo : hi;
        end
    endtask

    initial begin
        int k;
        int ph;
        int r;
        logic [DELAY_W-1:0] bits_w;
        logic [DELAY_W-1:0] delay_w;
        t_sample s;

        dir_tab = '{
            '{ROW_STEP, CFG_RES, 20'd0, '{0, 0, 0, 1, 1000, 1, 0}, 1'b1, '{0, 0, 0, 1, 0, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{500, 1, 0, 0, 1000, 1, 0}, 1'b1, '{0, 0, 0, 0, 1, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{0, 1, 1000, 1, 1000, 1, 0}, 1'b1, '{0, 0, 0, 0, 0, 1}},
            '{ROW_STEP, CFG_RES, 20'd0, '{500, 1, 0, 1, 1000, 1, 0}, 1'b1, '{128, 1, 0, 0, 0, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{100000, 1, -100000, 1, 100000, 1, 10}, 1'b1,
                '{255, 1, 0, 0, 0, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{-100000, 1, -100000, 1, 100000, 1, 10}, 1'b1,
                '{0, 1, 0, 0, 0, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{-100000, 1, -50000, 1, 50000, 1, 20}, 1'b1,
                '{0, 1, 0, 0, 0, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{100000, 1, -50000, 1, 50000, 1, 20}, 1'b1,
                '{255, 1, 0, 0, 0, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{1, 1, 0, 1, 510, 1, 30}, 1'b1, '{1, 1, 0, 0, 0, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{0, 1, 100000, 1, -100000, 1, 40}, 1'b1,
                '{1, 1, 0, 0, 0, 1}},
            '{ROW_STEP, CFG_RES, 20'd0, '{0, 0, 0, 0, 0, 0, 50}, 1'b1, '{1, 1, 0, 1, 1, 0}},
            '{ROW_CFG, CFG_DELAY, 20'd100, NO_SAMPLE, 1'b0, NO_READ},
            '{ROW_STEP, CFG_RES, 20'd0, '{0, 1, 0, 1, 1000, 1, 1000}, 1'b1, '{1, 1, 1, 0, 0, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{0, 1, 0, 1, 1000, 1, 1050}, 1'b1, '{1, 1, 1, 0, 0, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{1000, 1, 0, 1, 1000, 1, 1060}, 1'b1,
                '{1, 1, 1, 0, 0, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{0, 0, 0, 1, 1000, 1, 1160}, 1'b1,
                '{255, 1, 0, 1, 0, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{0, 1, 0, 1, 1000, 1, 500}, 1'b1, '{255, 1, 1, 0, 0, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{0, 0, 0, 1, 1000, 1, 600}, 1'b1, '{0, 1, 0, 1, 0, 0}},
            '{ROW_CFG, CFG_DELAY, 20'hFFFFF, NO_SAMPLE, 1'b0, NO_READ},
            '{ROW_STEP, CFG_RES, 20'd0, '{1000, 1, 0, 1, 1000, 1, 48'hFFFF_FFFF_FFF6}, 1'b1,
                '{0, 1, 1, 0, 0, 0}},
            '{ROW_STEP, CFG_RES, 20'd0, '{0, 0, 0, 1, 1000, 1, 48'hFFFF_FFFF_FFFF}, 1'b1,
                '{255, 1, 0, 1, 0, 0}},
            '{ROW_CFG, CFG_RES, 20'd15, NO_SAMPLE, 1'b0, NO_READ},
            '{ROW_STEP, CFG_RES, 20'd0, '{1000, 1, 0, 1, 1000, 1, 0}, 1'b1,
                '{255, 1, 1, 0, 0, 0}},
            '{ROW_CFG, CFG_RES, 20'd1, NO_SAMPLE, 1'b0, NO_READ},
            '{ROW_STEP, CFG_RES, 20'd0, '{0, 0, 0, 1, 1000, 1, 1000000}, 1'b1,
                '{3, 1, 0, 1, 0, 0}},
            '{ROW_CFG, CFG_RES, 20'h10, NO_SAMPLE, 1'b0, NO_READ},
            '{ROW_CFG, CFG_DELAY, 20'd0, NO_SAMPLE, 1'b0, NO_READ},
            '{ROW_STEP, CFG_RES, 20'd0, '{500, 1, 0, 1, 1000, 1, 5}, 1'b0, NO_READ},
            '{ROW_CFG, CFG_RES, 20'd8, NO_SAMPLE, 1'b0, NO_READ}
        };

        mismatches = 0;
        n_results = 0;
        pin_on = 1'b0;
        pin_reading = NO_READ;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        hold_off_req = 1'b0;
        now_t = '0;
        last_lo = 0;
        last_hi = 1000;
        last_vin = 500;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_vin_mv = '0;
        i_vin_connected = 1'b0;
        i_vref_low_mv = '0;
        i_vref_low_connected = 1'b0;
        i_vref_high_mv = '0;
        i_vref_high_connected = 1'b0;
        i_now_us = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_RES;
        i_cfg_data = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (k = 0; k < NDIR; k++) begin
            if (dir_tab[k].kind == ROW_CFG) begin
                settle();
                write_reg(dir_tab[k].cfg_idx, dir_tab[k].cfg_data);
                i_cfg_valid <= 1'b0;
            end else begin
                pin_on = dir_tab[k].pin;
                pin_reading = dir_tab[k].r;
                send(dir_tab[k].s);
            end
        end
        pin_on = 1'b0;

        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    bits_w = 20'd12;
                    delay_w = 20'd0;
                end
                1: begin
                    bits_w = 20'd1;
                    delay_w = 20'hFFFFF;
                end
                2: begin
                    bits_w = 20'd8;
                    delay_w = DELAY_MAX;
                end
                default: begin
                    bits_w = {16'($urandom_range(0, 16'hFFFF)), 4'($urandom_range(0, 15))};
                    r = $urandom_range(0, 99);
                    if (r < 30) delay_w = '0;
                    else if (r < 60) delay_w = DELAY_W'($urandom_range(1, 64));
                    else if (r < 85) delay_w = DELAY_W'($urandom_range(1000, 1000000));
                    else delay_w = DELAY_W'($urandom());
                end
            endcase
            settle();
            write_reg(CFG_RES, bits_w);
            write_reg(CFG_DELAY, delay_w);
            i_cfg_valid <= 1'b0;
            tx_quiet = (ph == 4) || (ph == 6);
            rx_quiet = (ph == 4);
            // back the result side up so the input stalls under steady requests
            if (ph == 6) hold_off_req = 1'b1;
            repeat (PHASE_ITEMS) begin
                make_sample(s);
                send(s);
            end
        end

        i_valid <= 1'b0;
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
